// File: rtl/core/dns_query_name_decoder_unit_defines.svh
// assertion macros used by the checker file
`ifndef DNS_QUERY_NAME_DECODER_UNIT_DEFINES_SVH
`define DNS_QUERY_NAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define DQND_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dqnd check failed");

// next-cycle implication
`define DQND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dqnd check failed");

`endif

// File: rtl/core/dqnd_pkg.sv
package dqnd_pkg;

  localparam int unsigned NAME_CAP = 255;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] MAX_LABEL_LEN = 8'd63;
  localparam logic [3:0] ADDR_FIELD_START = 4'd10;
  localparam logic [3:0] LAST_RR_FIELD = 4'd13;
  localparam logic [15:0] RR_TYPE_A = 16'd1;
  localparam logic [15:0] RR_LEN_A = 16'd4;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] STATUS_SHORT = 2'd0;
  localparam logic [1:0] STATUS_NO_QUESTION = 2'd1;
  localparam logic [1:0] STATUS_NAME = 2'd2;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       end_of_capture;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_char;
    logic [1:0]  parse_status;
    logic        is_response;
    logic        answer_valid;
    logic [31:0] answer_addr;
    logic        last_of_run;
  } out_word_t;

  // everything one byte leaves for the back end
  typedef struct packed {
    logic        emit_char;
    logic [7:0]  char_val;
    logic        emit_sum;
    logic [1:0]  status;
    logic        is_resp;
    logic        ans_valid;
    logic [31:0] addr;
  } action_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/dqnd_parser.sv
module dqnd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  dqnd_pkg::in_word_t item_i,
  output logic              act_valid_o,
  output dqnd_pkg::action_t act_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_CHARS,
    PH_SKIP,
    PH_ANAME,
    PH_RR,
    PH_DONE
  } phase_e;

  localparam logic [7:0] CapInit = 8'(dqnd_pkg::NAME_CAP);

  phase_e      phase_q, phase_d;
  logic [3:0]  hpos_q, hpos_d;
  logic [5:0]  label_q, label_d;
  logic [7:0]  chars_q, chars_d;
  logic        first_q, first_d;
  logic        resp_q, resp_d;
  logic        hasq_q, hasq_d;
  logic        hasa_q, hasa_d;
  logic [3:0]  fc_q, fc_d;
  logic [15:0] rtype_q, rtype_d;
  logic [15:0] rlen_q, rlen_d;
  logic [31:0] addr_q, addr_d;
  logic        found_q, found_d;
  phase_e      after_name;
  logic [7:0]  b;

  assign b = item_i.msg_byte;
  assign after_name = (resp_q && hasa_q) ? PH_SKIP : PH_DONE;

  always_comb begin
    phase_d = phase_q;
    hpos_d = hpos_q;
    label_d = label_q;
    chars_d = chars_q;
    first_d = first_q;
    resp_d = resp_q;
    hasq_d = hasq_q;
    hasa_d = hasa_q;
    fc_d = fc_q;
    rtype_d = rtype_q;
    rlen_d = rlen_q;
    addr_d = addr_q;
    found_d = found_q;
    act_o = '0;
    if (take_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hpos_q == 4'd2) resp_d = b[7];
          if ((hpos_q == 4'd4 || hpos_q == 4'd5) && b != 8'd0) hasq_d = 1'b1;
          if ((hpos_q == 4'd6 || hpos_q == 4'd7) && b != 8'd0) hasa_d = 1'b1;
          if (hpos_q == 4'd11) phase_d = hasq_d ? PH_LEN : PH_DONE;
          hpos_d = hpos_q + 4'd1;
        end
        PH_LEN: begin
          if (b == 8'd0) begin
            phase_d = after_name;
            fc_d = 4'd4;
          end else begin
            if (!first_q && chars_q != 8'd0) begin
              act_o.emit_char = 1'b1;
              act_o.char_val = dqnd_pkg::DOT_CHAR;
              chars_d = chars_q - 8'd1;
            end
            first_d = 1'b0;
            if (b > dqnd_pkg::MAX_LABEL_LEN) begin
              phase_d = after_name;
              fc_d = 4'd5;
            end else begin
              label_d = b[5:0];
              phase_d = PH_CHARS;
            end
          end
        end
        PH_CHARS: begin
          if (chars_q != 8'd0) begin
            act_o.emit_char = 1'b1;
            act_o.char_val = b;
            chars_d = chars_q - 8'd1;
          end
          label_d = label_q - 6'd1;
          if (label_d == 6'd0) phase_d = PH_LEN;
        end
        PH_SKIP: begin
          fc_d = fc_q - 4'd1;
          if (fc_d == 4'd0) phase_d = PH_ANAME;
        end
        PH_ANAME: begin
          if (b == 8'd0) begin
            phase_d = PH_RR;
            fc_d = 4'd0;
          end
        end
        PH_RR: begin
          if (fc_q < 4'd2) begin
            rtype_d = {rtype_q[7:0], b};
          end else if (fc_q == 4'd8 || fc_q == 4'd9) begin
            rlen_d = {rlen_q[7:0], b};
          end else if (fc_q >= dqnd_pkg::ADDR_FIELD_START) begin
            addr_d = {addr_q[23:0], b};
          end
          if (fc_q >= dqnd_pkg::LAST_RR_FIELD) begin
            if (rtype_q == dqnd_pkg::RR_TYPE_A && rlen_q == dqnd_pkg::RR_LEN_A) begin
              found_d = 1'b1;
            end
            phase_d = PH_DONE;
          end
          fc_d = fc_q + 4'd1;
        end
        default: begin
        end
      endcase

      if (item_i.end_of_capture) begin
        act_o.emit_sum = 1'b1;
        if (phase_d == PH_HEADER) act_o.status = dqnd_pkg::STATUS_SHORT;
        else if (!hasq_d) act_o.status = dqnd_pkg::STATUS_NO_QUESTION;
        else act_o.status = dqnd_pkg::STATUS_NAME;
        act_o.is_resp = (phase_d == PH_HEADER) ? 1'b0 : resp_d;
        act_o.ans_valid = found_d;
        act_o.addr = found_d ? addr_d : 32'd0;
        phase_d = PH_HEADER;
        hpos_d = 4'd0;
        label_d = 6'd0;
        chars_d = CapInit;
        first_d = 1'b1;
        resp_d = 1'b0;
        hasq_d = 1'b0;
        hasa_d = 1'b0;
        fc_d = 4'd0;
        rtype_d = 16'd0;
        rlen_d = 16'd0;
        addr_d = 32'd0;
        found_d = 1'b0;
      end
    end
    act_valid_o = act_o.emit_char | act_o.emit_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hpos_q <= 4'd0;
      label_q <= 6'd0;
      chars_q <= CapInit;
      first_q <= 1'b1;
      resp_q <= 1'b0;
      hasq_q <= 1'b0;
      hasa_q <= 1'b0;
      fc_q <= 4'd0;
      rtype_q <= 16'd0;
      rlen_q <= 16'd0;
      addr_q <= 32'd0;
      found_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hpos_q <= hpos_d;
      label_q <= label_d;
      chars_q <= chars_d;
      first_q <= first_d;
      resp_q <= resp_d;
      hasq_q <= hasq_d;
      hasa_q <= hasa_d;
      fc_q <= fc_d;
      rtype_q <= rtype_d;
      rlen_q <= rlen_d;
      addr_q <= addr_d;
      found_q <= found_d;
    end
  end

endmodule

// File: rtl/core/dqnd_fifo.sv
module dqnd_fifo #(
  parameter int unsigned DEPTH = dqnd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  dqnd_pkg::action_t    wr_data_i,
  input  logic                 rd_en_i,
  output dqnd_pkg::action_t    rd_data_o,
  output dqnd_pkg::q_status_t  status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  dqnd_pkg::action_t mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign status_o.full = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_wr = wr_en_i && !status_o.full;
  assign do_rd = rd_en_i && !status_o.empty;
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d = cnt_q;
    if (do_wr) wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + AW'(1);
    if (do_rd) rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + AW'(1);
    if (do_wr && !do_rd) cnt_d = cnt_q + CW'(1);
    else if (do_rd && !do_wr) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/dqnd_emitter.sv
module dqnd_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqnd_pkg::action_t   head_i,
  input  logic                q_empty_i,
  input  logic                pop_i,
  output logic                release_o,
  output logic                empty_o,
  output dqnd_pkg::out_word_t result_o
);

  logic char_done_q, char_done_d;
  logic show_char;
  logic take;

  assign empty_o = q_empty_i;
  assign show_char = head_i.emit_char && !char_done_q;
  assign take = pop_i && !q_empty_i;
  // an entry with both words stays until its summary goes
  assign release_o = take && !(show_char && head_i.emit_sum);

  always_comb begin
    char_done_d = char_done_q;
    if (take) char_done_d = show_char && head_i.emit_sum;
  end

  always_comb begin
    result_o = '0;
    if (show_char) begin
      result_o.result_kind = dqnd_pkg::KIND_CHAR;
      result_o.name_char = head_i.char_val;
    end else begin
      result_o.result_kind = dqnd_pkg::KIND_SUMMARY;
      result_o.parse_status = head_i.status;
      result_o.is_response = head_i.is_resp;
      result_o.answer_valid = head_i.ans_valid;
      result_o.answer_addr = head_i.addr;
      result_o.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_done_q <= 1'b0;
    end else begin
      char_done_q <= char_done_d;
    end
  end

endmodule

// File: rtl/core/dns_query_name_decoder_unit.sv
// DNS question-name decoder: takes one message byte per cycle and returns the decoded
// first question name one character per word, then a summary word (status, response
// flag, type-A answer address) on the byte marked end_of_capture. A byte is accepted
// every cycle while full is low; its parsing is a combinational update of the byte
// parser's phase and counters, registered at the clock, so one byte per cycle is
// sustained. Its results are written into a queue of QUEUE_DEPTH entries when the byte
// is taken and show on the result ports once they reach the queue head. Each entry
// yields one word, or two (a name character or dot, then the summary) for a final byte
// that also emits a character, and each pop while empty is low takes one word; full
// rises only when the queue holds QUEUE_DEPTH entries not yet drained.
module dns_query_name_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = dqnd_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  dqnd_pkg::in_word_t  item_i,
  output logic                empty,
  input  logic                pop,
  output dqnd_pkg::out_word_t result_o
);

  dqnd_pkg::action_t   act, head;
  dqnd_pkg::q_status_t q_status;
  logic                act_valid;
  logic                take;
  logic                release_head;

  assign full = q_status.full;
  assign take = push && !q_status.full;

  dqnd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .item_i     (item_i),
    .act_valid_o(act_valid),
    .act_o      (act)
  );

  dqnd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (act_valid),
    .wr_data_i(act),
    .rd_en_i  (release_head),
    .rd_data_o(head),
    .status_o (q_status)
  );

  dqnd_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_empty_i (q_status.empty),
    .pop_i     (pop),
    .release_o (release_head),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule

// File: rtl/core/dqnd_checker.sv
`include "dns_query_name_decoder_unit_defines.svh"

module dqnd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input dqnd_pkg::in_word_t  item_i,
  input logic                empty,
  input logic                pop,
  input dqnd_pkg::out_word_t result_o
);

  // a waiting word holds until taken
  `DQND_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_o))

  // the final byte always leaves a summary behind
  `DQND_ASSERT_NEXT(a_eoc_result, clk_i, rst_ni, push && !full && item_i.end_of_capture,
    !empty)

  // without a pop the queue cannot drain
  `DQND_ASSERT_NEXT(a_full_stays, clk_i, rst_ni, full && !(pop && !empty), full)

endmodule

bind dns_query_name_decoder_unit dqnd_checker u_dqnd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .push    (push),
  .full    (full),
  .item_i  (item_i),
  .empty   (empty),
  .pop     (pop),
  .result_o(result_o)
);
